[rtl/pqrm_pkg.sv]
// shared types and constants for the priority queue with arrival-order tie break
`timescale 1ns / 1ps

package pqrm_pkg;

	localparam int QUEUE_DEPTH_DEFAULT = 16;

	localparam int DATA_W  = 32;
	localparam int PRIO_W  = 16;
	localparam int TOP_W   = 17;
	localparam int COUNT_W = 5;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		STATUS_DONE  = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2
	} status_t;

	// per-cycle commands from the controller to every cell
	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctl_t;

	// running best entry handed from cell to cell
	typedef struct packed {
		logic              found;
		logic [PRIO_W-1:0] prio;
		logic [DATA_W-1:0] data;
	} carry_t;

endpackage

[rtl/pqrm_cell.sv]
// one queue slot: holds an entry and forwards the running best entry to its neighbor
`timescale 1ns / 1ps

module pqrm_cell #(
	parameter int QUEUE_DEPTH = pqrm_pkg::QUEUE_DEPTH_DEFAULT,
	parameter int CELL_INDEX  = 0,
	parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1),
	parameter int IDX_W       = $clog2(QUEUE_DEPTH)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  pqrm_pkg::cell_ctl_t        ctl,
	input  logic [CNT_W-1:0]           count,
	input  logic [IDX_W-1:0]           best_idx,
	input  logic [pqrm_pkg::DATA_W-1:0] new_data,
	input  logic [pqrm_pkg::PRIO_W-1:0] new_prio,
	input  logic [pqrm_pkg::DATA_W-1:0] next_data,
	input  logic [pqrm_pkg::PRIO_W-1:0] next_prio,
	input  pqrm_pkg::carry_t           carry_in,
	input  logic [IDX_W-1:0]           carry_idx_in,
	output logic [pqrm_pkg::DATA_W-1:0] data,
	output logic [pqrm_pkg::PRIO_W-1:0] prio,
	output pqrm_pkg::carry_t           carry_out,
	output logic [IDX_W-1:0]           carry_idx_out
);

	localparam bit IS_LAST = (CELL_INDEX == QUEUE_DEPTH - 1);

	logic [pqrm_pkg::DATA_W-1:0] data_q;
	logic [pqrm_pkg::PRIO_W-1:0] prio_q;
	pqrm_pkg::carry_t            carry_q;
	logic [IDX_W-1:0]            carry_idx_q;
	logic                        live;
	logic                        take;
	logic                        do_load;
	logic                        do_shift;

	assign live     = CNT_W'(CELL_INDEX) < count;
	assign do_load  = ctl.load && (count == CNT_W'(CELL_INDEX));
	assign do_shift = ctl.shift && !IS_LAST && (IDX_W'(CELL_INDEX) >= best_idx);
	// strict compare keeps the earliest entry on a tie
	assign take     = live && (!carry_in.found || (prio_q > carry_in.prio));

	always_ff @(posedge clk) begin
		if (do_load) begin
			data_q <= new_data;
			prio_q <= new_prio;
		end else if (do_shift) begin
			data_q <= next_data;
			prio_q <= next_prio;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q     <= '0;
			carry_idx_q <= '0;
		end else if (take) begin
			carry_q.found <= 1'b1;
			carry_q.prio  <= prio_q;
			carry_q.data  <= data_q;
			carry_idx_q   <= IDX_W'(CELL_INDEX);
		end else begin
			carry_q     <= carry_in;
			carry_idx_q <= carry_idx_in;
		end
	end

	assign data          = data_q;
	assign prio          = prio_q;
	assign carry_out     = carry_q;
	assign carry_idx_out = carry_idx_q;

endmodule

[rtl/priority_queue_remove_max_core.sv]
// top level: bounded priority queue, removal of the earliest highest-priority entry
`timescale 1ns / 1ps
//
// channel  dir  handshake                    payload
// s_axis   in   s_axis_tvalid/s_axis_tready  tdata: data_value, item_priority; tuser: mode
// m_axis   out  m_axis_tvalid/m_axis_tready  tdata: removed_data .. entry_count; tuser: status
//
// an insert, a dropped insert or a remove on an empty queue goes from idle straight to the final step
// a remove passes through a find step and a top step: the best-entry carry has to ripple
// through all QUEUE_DEPTH cells once to find the entry and once more for the new top
// a remove that follows an insert waits for the carry chain to settle first
// reset clears the count and the chain; entries themselves are not cleared
// a result waiting at m_axis holds the block in its final step until taken

module priority_queue_remove_max_core #(
	parameter int QUEUE_DEPTH = pqrm_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // data_value[31:0], item_priority[47:32]
	input  logic        s_axis_tuser,  // mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,  // removed_data[31:0], removed_priority[47:32],
	                                   // top_priority[64:48], entry_count[69:65], zero
	output logic [1:0]  m_axis_tuser   // status
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int IDX_W = $clog2(QUEUE_DEPTH);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_FIND = 4'b0010,
		ST_TOP  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t                          state_q;
	logic [CNT_W-1:0]                count_q;
	logic [CNT_W-1:0]                settle_q;
	logic [pqrm_pkg::TOP_W-1:0]      top_q;
	logic [pqrm_pkg::DATA_W-1:0]     res_data_q;
	logic [pqrm_pkg::PRIO_W-1:0]     res_prio_q;
	pqrm_pkg::status_t               res_status_q;
	logic                            out_valid_q;
	logic [71:0]                     out_data_q;
	logic [1:0]                      out_user_q;

	logic                            accept;
	logic                            is_insert;
	logic                            full;
	logic                            settled;
	logic                            out_free;
	logic [pqrm_pkg::DATA_W-1:0]     in_data;
	logic [pqrm_pkg::PRIO_W-1:0]     in_prio;
	pqrm_pkg::cell_ctl_t             ctl;

	logic [pqrm_pkg::DATA_W-1:0]     cell_data [QUEUE_DEPTH];
	logic [pqrm_pkg::PRIO_W-1:0]     cell_prio [QUEUE_DEPTH];
	pqrm_pkg::carry_t                carry_w   [QUEUE_DEPTH+1];
	logic [IDX_W-1:0]                carry_idx [QUEUE_DEPTH+1];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign is_insert     = (s_axis_tuser == pqrm_pkg::MODE_INSERT);
	assign in_data       = s_axis_tdata[31:0];
	assign in_prio       = s_axis_tdata[47:32];
	assign full          = (count_q == CNT_W'(QUEUE_DEPTH));
	assign settled       = (settle_q == '0);
	assign out_free      = !out_valid_q || m_axis_tready;

	assign ctl.load  = accept && is_insert && !full;
	assign ctl.shift = (state_q == ST_FIND) && settled;

	assign carry_w[0]   = '0;
	assign carry_idx[0] = '0;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic [pqrm_pkg::DATA_W-1:0] nxt_data;
		logic [pqrm_pkg::PRIO_W-1:0] nxt_prio;

		if (i < QUEUE_DEPTH - 1) begin : g_mid
			assign nxt_data = cell_data[i+1];
			assign nxt_prio = cell_prio[i+1];
		end else begin : g_end
			assign nxt_data = '0;
			assign nxt_prio = '0;
		end

		pqrm_cell #(
			.QUEUE_DEPTH(QUEUE_DEPTH),
			.CELL_INDEX (i),
			.CNT_W      (CNT_W),
			.IDX_W      (IDX_W)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctl          (ctl),
			.count        (count_q),
			.best_idx     (carry_idx[QUEUE_DEPTH]),
			.new_data     (in_data),
			.new_prio     (in_prio),
			.next_data    (nxt_data),
			.next_prio    (nxt_prio),
			.carry_in     (carry_w[i]),
			.carry_idx_in (carry_idx[i]),
			.data         (cell_data[i]),
			.prio         (cell_prio[i]),
			.carry_out    (carry_w[i+1]),
			.carry_idx_out(carry_idx[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			settle_q     <= '0;
			top_q        <= '1;
			res_data_q   <= '0;
			res_prio_q   <= '0;
			res_status_q <= pqrm_pkg::STATUS_DONE;
			out_valid_q  <= 1'b0;
			out_data_q   <= '0;
			out_user_q   <= '0;
		end else begin
			if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (!settled) begin
				settle_q <= settle_q - 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_data_q   <= '0;
						res_prio_q   <= '0;
						res_status_q <= pqrm_pkg::STATUS_DONE;
						state_q      <= ST_DONE;
						if (is_insert) begin
							if (full) begin
								res_status_q <= pqrm_pkg::STATUS_FULL;
							end else begin
								count_q  <= count_q + 1'b1;
								settle_q <= CNT_W'(QUEUE_DEPTH);
								if (top_q[pqrm_pkg::TOP_W-1] || (in_prio > top_q[15:0])) begin
									top_q <= {1'b0, in_prio};
								end
							end
						end else if (count_q == '0) begin
							res_status_q <= pqrm_pkg::STATUS_EMPTY;
						end else begin
							state_q <= ST_FIND;
						end
					end
				end
				ST_FIND: begin
					if (settled) begin
						res_data_q <= carry_w[QUEUE_DEPTH].data;
						res_prio_q <= carry_w[QUEUE_DEPTH].prio;
						count_q    <= count_q - 1'b1;
						settle_q   <= CNT_W'(QUEUE_DEPTH);
						state_q    <= ST_TOP;
					end
				end
				ST_TOP: begin
					if (settled) begin
						if (count_q == '0) begin
							top_q <= '1;
						end else begin
							top_q <= {1'b0, carry_w[QUEUE_DEPTH].prio};
						end
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_data_q  <= {2'b00, pqrm_pkg::COUNT_W'(count_q), top_q,
						                res_prio_q, res_data_q};
						out_user_q  <= res_status_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

endmodule

[rtl/pqrm_checker.sv]
// port-level checks on the priority queue results, bound to the top level
`timescale 1ns / 1ps

module pqrm_checker #(
	parameter int QUEUE_DEPTH = pqrm_pkg::QUEUE_DEPTH_DEFAULT
) (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [71:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);

	logic [15:0] rprio;
	logic [16:0] top;
	logic [4:0]  count;

	assign rprio = m_axis_tdata[47:32];
	assign top   = m_axis_tdata[64:48];
	assign count = m_axis_tdata[69:65];

	// a dropped insert only happens with every slot taken
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == pqrm_pkg::STATUS_FULL) |->
		count == 5'(QUEUE_DEPTH))
		else $error("full status with a non-full count");

	// a remove on an empty queue leaves it empty with no top
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == pqrm_pkg::STATUS_EMPTY) |->
		(count == 5'd0) && (top == 17'h1ffff) && (rprio == 16'd0))
		else $error("empty-remove result inconsistent");

	// an empty queue reports no top priority
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (count == 5'd0) && (QUEUE_DEPTH < 32) |-> top == 17'h1ffff)
		else $error("top priority shown for an empty queue");

	// the removed entry was the best one, so nothing left can beat it
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == pqrm_pkg::STATUS_DONE) && (rprio != 16'd0) &&
		(top != 17'h1ffff) |-> top[15:0] <= rprio)
		else $error("remaining top exceeds removed priority");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
		$stable(m_axis_tuser))
		else $error("stalled result changed");

endmodule

bind priority_queue_remove_max_core pqrm_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_pqrm_checker (.*);

[dv/testbench.sv]
// self-checking testbench for the priority queue with arrival-order tie break
`timescale 1ns / 1ps

module testbench;

	localparam int DEPTH         = pqrm_pkg::QUEUE_DEPTH_DEFAULT;
	localparam int RANDOM_ITEMS  = 736;
	localparam int CALM_ITEMS    = 100;
	localparam int LONG_HOLD     = 300;
	localparam int SETTLE_CYCLES = 2 * DEPTH + 8;
	localparam int WATCHDOG_MAX  = 2000;

	typedef struct packed {
		logic [pqrm_pkg::DATA_W-1:0]  rdata;
		logic [pqrm_pkg::PRIO_W-1:0]  rprio;
		pqrm_pkg::status_t            status;
		logic [pqrm_pkg::TOP_W-1:0]   top;
		logic [pqrm_pkg::COUNT_W-1:0] count;
	} pq_result_t;

	typedef enum {ROUND_FILL, ROUND_DRAIN, ROUND_MIXED} round_kind_t;

	// predicts each transaction's result and checks results in order
	class pq_scoreboard;
		logic [pqrm_pkg::DATA_W-1:0] data_q[DEPTH];
		logic [pqrm_pkg::PRIO_W-1:0] prio_q[DEPTH];
		int unsigned                 held;
		pq_result_t                  results_q[$];
		int                          mismatches;

		function new();
			held       = 0;
			mismatches = 0;
		endfunction

		// earliest slot of the largest priority, held > 0
		function int best_slot();
			int b;
			b = 0;
			for (int i = 1; i < held; i++)
				if (prio_q[i] > prio_q[b])
					b = i;
			return b;
		endfunction

		function void note_input(logic mode, logic [pqrm_pkg::DATA_W-1:0] d,
		                         logic [pqrm_pkg::PRIO_W-1:0] p);
			pq_result_t r;
			int         b;
			r        = '0;
			r.status = pqrm_pkg::STATUS_DONE;
			if (mode == pqrm_pkg::MODE_INSERT) begin
				if (held >= DEPTH) begin
					r.status = pqrm_pkg::STATUS_FULL;
				end else begin
					data_q[held] = d;
					prio_q[held] = p;
					held++;
				end
			end else if (held == 0) begin
				r.status = pqrm_pkg::STATUS_EMPTY;
			end else begin
				b       = best_slot();
				r.rdata = data_q[b];
				r.rprio = prio_q[b];
				// close the gap so arrival order is kept
				for (int i = b; i + 1 < held; i++) begin
					data_q[i] = data_q[i + 1];
					prio_q[i] = prio_q[i + 1];
				end
				held--;
			end
			r.top   = (held == 0) ? '1 : {1'b0, prio_q[best_slot()]};
			r.count = pqrm_pkg::COUNT_W'(held);
			results_q.push_back(r);
		endfunction

		function void check_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				if (mismatches < 10)
					$display("mismatch on %s: expected %h, actual %h", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(logic [71:0] tdata, logic [1:0] tuser);
			pq_result_t r;
			if (results_q.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result: tdata %h tuser %h", tdata, tuser);
				mismatches++;
				return;
			end
			r = results_q.pop_front();
			check_field("removed_data", r.rdata, tdata[31:0]);
			check_field("removed_priority", 32'(r.rprio), 32'(tdata[47:32]));
			check_field("top_priority", 32'(r.top), 32'(tdata[64:48]));
			check_field("entry_count", 32'(r.count), 32'(tdata[69:65]));
			check_field("pad", 32'd0, 32'(tdata[71:70]));
			check_field("status", 32'(r.status), 32'(tuser));
		endfunction

		function int pending();
			return results_q.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [71:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;

	pq_scoreboard sb;
	bit           calm;
	bit           hold_req;
	int           idle_cycles = 0;

	priority_queue_remove_max_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// offer one transaction, with an occasional idle burst ahead of it
	task automatic send_item(input logic mode, input logic [31:0] d, input logic [15:0] p);
		int gap;
		@(negedge clk);
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 3);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {p, d};
		s_axis_tuser  <= mode;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_input(mode, d, p);
	endtask

	task automatic pause_until_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_prio();
		case ($urandom_range(0, 9))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			2, 3, 4, 5: return 16'($urandom_range(0, 3));  // lots of ties
			8:       return 16'($urandom_range(65532, 65535));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] pick_data();
		case ($urandom_range(0, 7))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// receiver: random short stalls, plus one long hold-off on request
	initial begin
		int  hold_left;
		int  stall_left;
		logic rdy;
		hold_left     = 0;
		stall_left    = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = LONG_HOLD - 1;
				rdy       = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rdy = 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 2);
				rdy        = 1'b0;
			end else begin
				rdy = 1'b1;
			end
			m_axis_tready <= rdy;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser);
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_MAX) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int          sent;
		int          round;
		int          round_len;
		round_kind_t kind;
		logic        mode;
		sb            = new();
		calm          = 1'b0;
		hold_req      = 1'b0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = pqrm_pkg::MODE_INSERT;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty remove, extremes, best entry at the head, ties
		send_item(pqrm_pkg::MODE_REMOVE, 32'h1234_5678, 16'hABCD);
		send_item(pqrm_pkg::MODE_INSERT, 32'h7FFF_FFFF, 16'hFFFF);
		send_item(pqrm_pkg::MODE_INSERT, 32'h8000_0000, 16'h0000);
		send_item(pqrm_pkg::MODE_INSERT, 32'h0000_0001, 16'h0005);
		send_item(pqrm_pkg::MODE_INSERT, 32'h0000_0002, 16'h0005);
		send_item(pqrm_pkg::MODE_REMOVE, 32'hFFFF_FFFF, 16'hFFFF);
		send_item(pqrm_pkg::MODE_REMOVE, 32'h0000_0000, 16'h0000);
		send_item(pqrm_pkg::MODE_INSERT, 32'h0000_0003, 16'h0005);
		send_item(pqrm_pkg::MODE_REMOVE, 32'h0000_0000, 16'h0000);
		send_item(pqrm_pkg::MODE_REMOVE, 32'h0000_0000, 16'h0000);
		send_item(pqrm_pkg::MODE_REMOVE, 32'h0000_0000, 16'h0000);
		send_item(pqrm_pkg::MODE_REMOVE, 32'h0000_0000, 16'h0000);
		send_item(pqrm_pkg::MODE_INSERT, 32'hFFFF_FFFF, 16'h0000);
		send_item(pqrm_pkg::MODE_REMOVE, 32'h0000_0000, 16'h0000);
		pause_until_drained();

		sent  = 0;
		round = 0;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 2))
				0:       kind = ROUND_FILL;
				1:       kind = ROUND_DRAIN;
				default: kind = ROUND_MIXED;
			endcase
			// open with a fill past full, then a drain past empty
			if (round == 0) kind = ROUND_FILL;
			if (round == 1) kind = ROUND_DRAIN;
			round_len = $urandom_range(20, 50);
			if (round == 2) hold_req = 1'b1;
			if (round == 5) pause_until_drained();
			for (int k = 0; k < round_len && sent < RANDOM_ITEMS; k++) begin
				if (sent >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
				case (kind)
					ROUND_FILL:  mode = ($urandom_range(0, 7) == 0) ?
					                    pqrm_pkg::MODE_REMOVE : pqrm_pkg::MODE_INSERT;
					ROUND_DRAIN: mode = ($urandom_range(0, 7) == 0) ?
					                    pqrm_pkg::MODE_INSERT : pqrm_pkg::MODE_REMOVE;
					default:     mode = $urandom_range(0, 1) ?
					                    pqrm_pkg::MODE_REMOVE : pqrm_pkg::MODE_INSERT;
				endcase
				if (round == 0) mode = pqrm_pkg::MODE_INSERT;
				if (round == 1) mode = pqrm_pkg::MODE_REMOVE;
				send_item(mode, pick_data(), pick_prio());
				sent++;
			end
			round++;
		end

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
